>>> hdl/cdd_pkg.sv
// Shared types, constants and codes for the CoDel drop decider.
`timescale 1ns / 1ps
`default_nettype none
package cdd_pkg;

  localparam int TIME_BITS  = 64;
  localparam int COUNT_BITS = 32;

  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    VERDICT_DELIVER = 2'd0,
    VERDICT_DROP    = 2'd1,
    VERDICT_EMPTY   = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CASCADE = 2'd1,
    PH_ENTRY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CFG_TARGET   = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_MAXBYTES = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXAM,
    S_DEC,
    S_SQRT,
    S_SQRT_WAIT,
    S_DIV_WAIT,
    S_ADD,
    S_FIN,
    S_OUT
  } state_t;

  // Handshake of an iterative arithmetic unit.
  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic done;
  } unit_sts_t;

endpackage
`default_nettype wire

>>> hdl/cdd_if.sv
// Channel interfaces for the packet beats in and the verdict beats out.
`timescale 1ns / 1ps
`default_nettype none
interface cdd_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        queue_empty;
  logic [63:0] enqueue_time;
  logic [63:0] time_now;
  logic [23:0] backlog_bytes;

  modport source (output valid, action, queue_empty, enqueue_time, time_now,
                  backlog_bytes, input ready);
  modport sink   (input valid, action, queue_empty, enqueue_time, time_now,
                  backlog_bytes, output ready);
endinterface

interface cdd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic        dropping_now;
  logic [31:0] drops_total;

  modport source (output valid, verdict, dropping_now, drops_total, input ready);
  modport sink   (input valid, verdict, dropping_now, drops_total, output ready);
endinterface
`default_nettype wire

>>> hdl/codel_drop_decider.sv
// Top level of the CoDel drop decider: request sequencer and drop state.
//
// Usage: each packet popped from the queue head comes in as one beat on
// pkt_in (action, queue_empty, enqueue_time, time_now, backlog_bytes). For
// each beat one verdict beat leaves on pkt_out: deliver, drop (pop the next
// packet and send it with action 1), or queue empty, with the dropping flag
// and the saturating drop total after that packet.
// An accepted beat passes the EXAM, DEC and OUT states. To recompute the
// next drop time, the 16-step square root unit and the 32-step divider run
// back to back between DEC and ADD; a cascade follow-up also passes FIN.
// One packet is in work at a time; pkt_in.ready is high only while idle,
// so the next packet is taken only after the last verdict is registered.
// A finished verdict sits in the output register; the next packet is taken
// while it waits, and a later verdict holds until pkt_out.ready takes it.
// Reset (rst, synchronous) clears all drop state and loads the register
// defaults: target 5, interval 100, max packet 1500 bytes.
// Configuration writes go through cfg_wr_en/cfg_index/cfg_wr_data while
// idle; the user must keep to that, as the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module codel_drop_decider (
  input  wire              clk,
  input  wire              rst,
  cdd_in_if.sink           pkt_in,
  cdd_out_if.source        pkt_out,
  input  wire              cfg_wr_en,
  input  wire  [1:0]       cfg_index,
  input  wire  [31:0]      cfg_wr_data
);

  cdd_pkg::state_t state, state_next;

  // Configuration.
  logic [31:0] target_delay;
  logic [31:0] interval_len;
  logic [15:0] max_packet_bytes;

  // Drop state.
  cdd_pkg::time_t  first_above;
  logic            above_valid;
  cdd_pkg::time_t  next_drop_time;
  cdd_pkg::count_t drop_rate_count;
  logic            in_dropping;
  logic [31:0]     total_dropped;
  cdd_pkg::phase_t request_phase;
  cdd_pkg::time_t  request_time;

  // Latched beat and step scratch.
  logic            act;
  logic            empty;
  cdd_pkg::time_t  enq;
  cdd_pkg::time_t  now;
  logic [23:0]     backlog;
  logic            newreq;
  logic            ok;
  logic            cascade;
  cdd_pkg::time_t  law_base;
  cdd_pkg::verdict_t verdict;

  // Arithmetic units.
  cdd_pkg::unit_ctl_t sqrt_ctl, div_ctl;
  cdd_pkg::unit_sts_t sqrt_sts, div_sts;
  logic [15:0] root;
  logic [15:0] root_r;
  logic [31:0] quot;

  cdd_pkg::time_t sojourn;
  cdd_pkg::time_t d_next;
  cdd_pkg::time_t d_first;
  logic           near_last;
  logic           long_above;

  assign sojourn    = now - enq;
  assign d_next     = request_time - next_drop_time;
  assign d_first    = request_time - first_above;
  assign near_last  = 64'(d_next) < 64'(interval_len);
  assign long_above = 64'(d_first) >= 64'(interval_len);

  assign sqrt_ctl.start = (state == cdd_pkg::S_SQRT);
  assign div_ctl.start  = (state == cdd_pkg::S_SQRT_WAIT) && sqrt_sts.done;

  assign root_r = (root == 16'd0) ? 16'd1 : root;

  cdd_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sqrt_ctl),
    .value (32'(drop_rate_count)),
    .sts   (sqrt_sts),
    .root  (root)
  );

  cdd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (interval_len),
    .divisor  (root_r),
    .sts      (div_sts),
    .quotient (quot)
  );

  assign pkt_in.ready = (state == cdd_pkg::S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cdd_pkg::S_IDLE: begin
        if (pkt_in.valid) state_next = cdd_pkg::S_EXAM;
      end
      cdd_pkg::S_EXAM: state_next = cdd_pkg::S_DEC;
      cdd_pkg::S_DEC: begin
        if (newreq) begin
          if (!empty && !in_dropping && ok && (near_last || long_above)) begin
            state_next = cdd_pkg::S_SQRT;
          end else begin
            state_next = cdd_pkg::S_OUT;
          end
        end else if (request_phase == cdd_pkg::PH_CASCADE && ok) begin
          state_next = cdd_pkg::S_SQRT;
        end else if (request_phase == cdd_pkg::PH_CASCADE) begin
          state_next = cdd_pkg::S_FIN;
        end else begin
          state_next = cdd_pkg::S_OUT;
        end
      end
      cdd_pkg::S_SQRT: state_next = cdd_pkg::S_SQRT_WAIT;
      cdd_pkg::S_SQRT_WAIT: begin
        if (sqrt_sts.done) state_next = cdd_pkg::S_DIV_WAIT;
      end
      cdd_pkg::S_DIV_WAIT: begin
        if (div_sts.done) state_next = cdd_pkg::S_ADD;
      end
      cdd_pkg::S_ADD: state_next = cascade ? cdd_pkg::S_FIN : cdd_pkg::S_OUT;
      cdd_pkg::S_FIN: state_next = cdd_pkg::S_OUT;
      cdd_pkg::S_OUT: begin
        if (!pkt_out.valid || pkt_out.ready) state_next = cdd_pkg::S_IDLE;
      end
      default: state_next = cdd_pkg::S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_delay     <= 32'd5;
      interval_len     <= 32'd100;
      max_packet_bytes <= 16'd1500;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cdd_pkg::CFG_TARGET:   target_delay     <= cfg_wr_data;
        cdd_pkg::CFG_INTERVAL: interval_len     <= cfg_wr_data;
        cdd_pkg::CFG_MAXBYTES: max_packet_bytes <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted beat.
  always_ff @(posedge clk) begin
    if (state == cdd_pkg::S_IDLE && pkt_in.valid) begin
      act     <= pkt_in.action;
      empty   <= pkt_in.queue_empty;
      enq     <= pkt_in.enqueue_time[cdd_pkg::TIME_BITS-1:0];
      now     <= pkt_in.time_now[cdd_pkg::TIME_BITS-1:0];
      backlog <= pkt_in.backlog_bytes;
    end
  end

  // Drop state and the step sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_above     <= '0;
      above_valid     <= 1'b0;
      next_drop_time  <= '0;
      drop_rate_count <= '0;
      in_dropping     <= 1'b0;
      total_dropped   <= '0;
      request_phase   <= cdd_pkg::PH_IDLE;
      request_time    <= '0;
      ok              <= 1'b0;
      newreq          <= 1'b0;
      cascade         <= 1'b0;
      verdict         <= cdd_pkg::VERDICT_DELIVER;
      law_base        <= '0;
    end else begin
      case (state)
        // Sojourn check and above-target tracking.
        cdd_pkg::S_EXAM: begin
          newreq <= !act || !(request_phase == cdd_pkg::PH_CASCADE ||
                              request_phase == cdd_pkg::PH_ENTRY);
          if (!act || !(request_phase == cdd_pkg::PH_CASCADE ||
                        request_phase == cdd_pkg::PH_ENTRY)) begin
            request_time <= now;
          end
          ok <= 1'b0;
          if (empty) begin
            above_valid <= 1'b0;
          end else if (64'(sojourn) < 64'(target_delay) ||
                       backlog < 24'(max_packet_bytes)) begin
            above_valid <= 1'b0;
          end else if (!above_valid) begin
            above_valid <= 1'b1;
            first_above <= now + cdd_pkg::time_t'(interval_len);
          end else if (now >= first_above) begin
            ok <= 1'b1;
          end
        end
        // Decide on the verdict or start the control law.
        cdd_pkg::S_DEC: begin
          cascade <= 1'b0;
          verdict <= empty ? cdd_pkg::VERDICT_EMPTY : cdd_pkg::VERDICT_DELIVER;
          if (newreq) begin
            request_phase <= cdd_pkg::PH_IDLE;
            if (empty) begin
              in_dropping <= 1'b0;
            end else if (in_dropping) begin
              if (!ok) begin
                in_dropping <= 1'b0;
              end else if (request_time >= next_drop_time) begin
                if (total_dropped != cdd_pkg::TOTAL_MAX) total_dropped <= total_dropped + 32'd1;
                if (drop_rate_count != cdd_pkg::COUNT_MAX) begin
                  drop_rate_count <= drop_rate_count + cdd_pkg::count_t'(1);
                end
                verdict       <= cdd_pkg::VERDICT_DROP;
                request_phase <= cdd_pkg::PH_CASCADE;
              end
            end else if (ok && (near_last || long_above)) begin
              if (total_dropped != cdd_pkg::TOTAL_MAX) total_dropped <= total_dropped + 32'd1;
              in_dropping <= 1'b1;
              if (near_last && drop_rate_count > cdd_pkg::count_t'(2)) begin
                drop_rate_count <= drop_rate_count - cdd_pkg::count_t'(2);
              end else begin
                drop_rate_count <= cdd_pkg::count_t'(1);
              end
              law_base      <= request_time;
              verdict       <= cdd_pkg::VERDICT_DROP;
              request_phase <= cdd_pkg::PH_ENTRY;
            end
          end else if (request_phase == cdd_pkg::PH_CASCADE) begin
            cascade  <= 1'b1;
            law_base <= next_drop_time;
            if (!ok) in_dropping <= 1'b0;
          end else begin
            request_phase <= cdd_pkg::PH_IDLE;
          end
        end
        // Advance the next drop time by interval / sqrt(count).
        cdd_pkg::S_ADD: begin
          next_drop_time <= law_base + cdd_pkg::time_t'(quot);
        end
        // Close a cascade step.
        cdd_pkg::S_FIN: begin
          if (in_dropping && request_time >= next_drop_time) begin
            if (total_dropped != cdd_pkg::TOTAL_MAX) total_dropped <= total_dropped + 32'd1;
            if (drop_rate_count != cdd_pkg::COUNT_MAX) begin
              drop_rate_count <= drop_rate_count + cdd_pkg::count_t'(1);
            end
            verdict <= cdd_pkg::VERDICT_DROP;
          end else begin
            request_phase <= cdd_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else if (state == cdd_pkg::S_OUT && (!pkt_out.valid || pkt_out.ready)) begin
      pkt_out.valid <= 1'b1;
    end else if (pkt_out.ready) begin
      pkt_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cdd_pkg::S_OUT && (!pkt_out.valid || pkt_out.ready)) begin
      pkt_out.verdict      <= verdict;
      pkt_out.dropping_now <= in_dropping;
      pkt_out.drops_total  <= total_dropped;
    end
  end

  // The control law never sees a zero count while dropping.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_dropping |-> drop_rate_count != '0)
    else $error("dropping with zero drop count");

  // The drop total never goes backward.
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> total_dropped >= $past(total_dropped))
    else $error("drop total decreased");

  // A pending entry follow-up implies the dropping state.
  a_entry_dropping: assert property (@(posedge clk) disable iff (rst)
    request_phase == cdd_pkg::PH_ENTRY |-> in_dropping)
    else $error("entry phase outside dropping state");

endmodule
`default_nettype wire

>>> hdl/cdd_isqrt.sv
// Iterative integer square root, two operand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cdd_isqrt (
  input  wire                     clk,
  input  wire                     rst,
  input  wire cdd_pkg::unit_ctl_t ctl,
  input  wire  [31:0]             value,
  output cdd_pkg::unit_sts_t      sts,
  output logic [15:0]             root
);

  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitm;
  logic        busy;
  logic        done;
  logic [31:0] trial;

  assign trial    = res + bitm;
  assign root     = res[15:0];
  assign sts.done = done;

  // Control: run until the probe bit falls off the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && bitm[1:0] != 2'b00) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: one result bit per step.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem  <= value;
      res  <= '0;
      bitm <= 32'h4000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule
`default_nettype wire

>>> hdl/cdd_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module cdd_div (
  input  wire                     clk,
  input  wire                     rst,
  input  wire cdd_pkg::unit_ctl_t ctl,
  input  wire  [31:0]             dividend,
  input  wire  [15:0]             divisor,
  output cdd_pkg::unit_sts_t      sts,
  output logic [31:0]             quotient
);

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [16:0] trial;
  logic        fits;

  assign trial    = {rem, quotient[31]};
  assign fits     = trial >= {1'b0, dvs};
  assign sts.done = done;

  // Control: 32 steps then report.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift dividend bits into the remainder.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= 16'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[15:0];
      end
      quotient <= {quotient[30:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> verif/codel_drop_decider_tb.sv
// Self-checking testbench for the CoDel drop decider: directed table, then random requests.
`timescale 1ns / 1ps
`default_nettype none
module codel_drop_decider_tb;
  import cdd_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wr_data = '0;

  cdd_in_if pkt_in ();
  cdd_out_if pkt_out ();

  codel_drop_decider u_top (
    .clk(clk), .rst(rst), .pkt_in(pkt_in.sink), .pkt_out(pkt_out.source),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic       action;
    logic       queue_empty;
    time_t      enqueue_time;
    time_t      time_now;
    logic [23:0] backlog_bytes;
  } pkt_t;

  typedef struct packed {
    verdict_t   verdict;
    logic       dropping_now;
    logic [31:0] drops_total;
  } verdict_beat_t;

  // Predictor copy of configuration and drop state
  logic [31:0] m_target, m_interval;
  logic [15:0] m_max_bytes;
  time_t       m_first_above, m_next_drop, m_req_time;
  logic        m_above_valid, m_dropping;
  count_t      m_rate_count;
  logic [31:0] m_total;
  phase_t      m_phase;

  verdict_beat_t verdicts_pending[$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off_cycles = 0;

  function automatic logic [31:0] int_sqrt(logic [31:0] v);
    logic [31:0] res, bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic time_t next_drop_from(time_t t);
    logic [31:0] r;
    r = int_sqrt(m_rate_count);
    if (r == 0) r = 1;
    return t + time_t'(m_interval / r);
  endfunction

  function automatic void bump_total();
    if (m_total != TOTAL_MAX) m_total++;
  endfunction

  function automatic void bump_rate();
    if (m_rate_count != COUNT_MAX) m_rate_count++;
  endfunction

  // Track sojourn above target; return 1 when a drop is allowed
  function automatic logic sojourn_check(pkt_t p);
    time_t soj;
    if (p.queue_empty) begin
      m_above_valid = 1'b0;
      return 1'b0;
    end
    soj = p.time_now - p.enqueue_time;
    if (soj < time_t'(m_target) || p.backlog_bytes < 24'(m_max_bytes)) begin
      m_above_valid = 1'b0;
    end else if (!m_above_valid) begin
      m_above_valid = 1'b1;
      m_first_above = p.time_now + time_t'(m_interval);
    end else if (p.time_now >= m_first_above) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_beat_t decide_verdict(pkt_t p);
    verdict_beat_t r;
    verdict_t v;
    logic ok;
    time_t since_next;
    v = VERDICT_DELIVER;
    if (p.action == 1'b0 || m_phase == PH_IDLE || m_phase == phase_t'(2'd3)) begin
      m_req_time = p.time_now;
      ok = sojourn_check(p);
      m_phase = PH_IDLE;
      since_next = m_req_time - m_next_drop;
      if (p.queue_empty) begin
        m_dropping = 1'b0;
        v = VERDICT_EMPTY;
      end else if (m_dropping) begin
        if (!ok) begin
          m_dropping = 1'b0;
        end else if (m_req_time >= m_next_drop) begin
          bump_total();
          bump_rate();
          v = VERDICT_DROP;
          m_phase = PH_CASCADE;
        end
      end else if (ok && (since_next < time_t'(m_interval) ||
                          (m_req_time - m_first_above) >= time_t'(m_interval))) begin
        bump_total();
        m_dropping = 1'b1;
        if (since_next < time_t'(m_interval))
          m_rate_count = (m_rate_count > 2) ? m_rate_count - 2 : 1;
        else
          m_rate_count = 1;
        m_next_drop = next_drop_from(m_req_time);
        v = VERDICT_DROP;
        m_phase = PH_ENTRY;
      end
    end else if (m_phase == PH_CASCADE) begin
      ok = sojourn_check(p);
      if (!ok) m_dropping = 1'b0;
      else m_next_drop = next_drop_from(m_next_drop);
      if (m_dropping && m_req_time >= m_next_drop) begin
        bump_total();
        bump_rate();
        v = VERDICT_DROP;
      end else begin
        v = p.queue_empty ? VERDICT_EMPTY : VERDICT_DELIVER;
        m_phase = PH_IDLE;
      end
    end else begin
      void'(sojourn_check(p));
      v = p.queue_empty ? VERDICT_EMPTY : VERDICT_DELIVER;
      m_phase = PH_IDLE;
    end
    r.verdict = v;
    r.dropping_now = m_dropping;
    r.drops_total = m_total;
    return r;
  endfunction

  // Predict on each accepted packet beat
  always @(posedge clk) begin
    if (!rst && pkt_in.valid && pkt_in.ready) begin
      pkt_t p;
      p = {pkt_in.action, pkt_in.queue_empty, pkt_in.enqueue_time, pkt_in.time_now,
           pkt_in.backlog_bytes};
      verdicts_pending.push_back(decide_verdict(p));
    end
  end

  // Compare each accepted verdict beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && pkt_out.valid && pkt_out.ready) begin
      verdict_beat_t want;
      if (verdicts_pending.size() == 0) begin
        $display("%0t: unexpected verdict beat %0d/%0b/%0d", $time, pkt_out.verdict,
                 pkt_out.dropping_now, pkt_out.drops_total);
        fail_count++;
      end else begin
        want = verdicts_pending.pop_front();
        if (pkt_out.verdict !== want.verdict || pkt_out.dropping_now !== want.dropping_now ||
            pkt_out.drops_total !== want.drops_total) begin
          $display("%0t: mismatch expected %0d/%0b/%0d actual %0d/%0b/%0d", $time,
                   want.verdict, want.dropping_now, want.drops_total, pkt_out.verdict,
                   pkt_out.dropping_now, pkt_out.drops_total);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((pkt_in.valid && pkt_in.ready) || (pkt_out.valid && pkt_out.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      pkt_out.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      pkt_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_TARGET:   m_target = val;
      CFG_INTERVAL: m_interval = val;
      default:      m_max_bytes = val[15:0];
    endcase
  endtask

  // Drive one packet beat from the falling edge and hold it until accepted
  task automatic send_pkt(pkt_t p);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    pkt_in.valid = 1'b1;
    {pkt_in.action, pkt_in.queue_empty, pkt_in.enqueue_time, pkt_in.time_now,
     pkt_in.backlog_bytes} = p;
    @(posedge clk);
    while (!pkt_in.ready) @(posedge clk);
    @(negedge clk);
    pkt_in.valid = 1'b0;
  endtask

  task automatic drain();
    while (verdicts_pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Random request: a new packet, then up to three follow-ups
  time_t clk_now = 64'd1000;
  task automatic send_request();
    pkt_t p;
    int n;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      clk_now += $urandom_range(0, 2 * m_interval > 400 ? 400 : 2 * m_interval);
      p.action = (k == 0) ? 1'b0 : 1'b1;
      if ($urandom_range(19) == 0) p.action = ~p.action;
      p.queue_empty = ($urandom_range(15) == 0);
      p.time_now = clk_now;
      p.enqueue_time = clk_now - $urandom_range(0, 3 * m_target + 20);
      p.backlog_bytes = ($urandom_range(9) == 0) ? 24'($urandom()) :
                        24'($urandom_range(0, 3 * m_max_bytes + 10));
      if ($urandom_range(49) == 0) begin
        p.enqueue_time = {$urandom(), $urandom()};
        p.time_now = {$urandom(), $urandom()};
      end
      send_pkt(p);
    end
  endtask

  typedef struct packed {
    pkt_t pkt;
    logic check_fixed;
    verdict_beat_t fixed;
  } row_t;

  row_t dir_rows[] = '{
    // empty queue right after reset
    '{'{1'b0, 1'b1, 64'd0, 64'd0, 24'd0}, 1'b1, '{VERDICT_EMPTY, 1'b0, 32'd0}},
    // low backlog is never above target
    '{'{1'b0, 1'b0, 64'd0, 64'd1000, 24'd0}, 1'b1, '{VERDICT_DELIVER, 1'b0, 32'd0}},
    // follow-up when idle, extreme fields
    '{'{1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 24'hFFFFFF}, 1'b1,
      '{VERDICT_DELIVER, 1'b0, 32'd0}},
    // build above-target, then enter dropping
    '{'{1'b0, 1'b0, 64'd100, 64'd200, 24'd5000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 64'd150, 64'd300, 24'd5000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 64'd150, 64'd400, 24'd5000}, 1'b0, '0},
    '{'{1'b1, 1'b0, 64'd390, 64'd401, 24'd5000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 64'd200, 64'd500, 24'd5000}, 1'b0, '0},
    '{'{1'b1, 1'b0, 64'd200, 64'd501, 24'd5000}, 1'b0, '0},
    '{'{1'b1, 1'b0, 64'd200, 64'd502, 24'd5000}, 1'b0, '0},
    // new request abandons a pending follow-up
    '{'{1'b0, 1'b0, 64'd0, 64'd700, 24'd5000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 64'd0, 64'd900, 24'd5000}, 1'b0, '0},
    // empty follow-up leaves dropping
    '{'{1'b1, 1'b1, 64'd0, 64'd901, 24'd0}, 1'b0, '0},
    // wrapped times
    '{'{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 64'd50, 24'h800000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 64'd300, 24'h800000}, 1'b0, '0},
    '{'{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FF00, 64'd600, 24'h800000}, 1'b0, '0}
  };

  initial begin
    verdict_beat_t want;
    pkt_in.valid = 1'b0;
    pkt_in.action = 1'b0;
    pkt_in.queue_empty = 1'b0;
    pkt_in.enqueue_time = '0;
    pkt_in.time_now = '0;
    pkt_in.backlog_bytes = '0;
    pkt_out.ready = 1'b0;
    m_target = 5; m_interval = 100; m_max_bytes = 1500;
    m_first_above = 0; m_next_drop = 0; m_req_time = 0;
    m_above_valid = 0; m_dropping = 0; m_rate_count = 0; m_total = 0;
    m_phase = PH_IDLE;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table; fixed rows also cross-check the predictor
    foreach (dir_rows[i]) begin
      if (dir_rows[i].check_fixed) begin
        send_pkt(dir_rows[i].pkt);
        want = verdicts_pending[verdicts_pending.size() - 1];
        if (want !== dir_rows[i].fixed) begin
          $display("%0t: table row %0d expected %p actual %p", $time, i,
                   dir_rows[i].fixed, want);
          fail_count++;
        end
      end else begin
        send_pkt(dir_rows[i].pkt);
      end
    end
    drain();

    // Extreme settings: zero interval, target and max bytes, then all-ones values
    write_reg(CFG_INTERVAL, 32'd0);
    write_reg(CFG_TARGET, 32'd0);
    write_reg(CFG_MAXBYTES, 32'd0);
    for (int i = 0; i < 40; i++) send_request();
    drain();
    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
    write_reg(CFG_TARGET, 32'hFFFF_FFFF);
    write_reg(CFG_MAXBYTES, 32'h0000_FFFF);
    for (int i = 0; i < 30; i++) send_request();
    drain();

    // Random phases over several settings and idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_TARGET, $urandom_range(1, 30));
      write_reg(CFG_INTERVAL, $urandom_range(1, 200));
      write_reg(CFG_MAXBYTES, $urandom_range(0, 3000));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 0) hold_off_cycles = 600;
      for (int i = 0; i < 120; i++) begin
        send_request();
        if (i == 60) while (verdicts_pending.size() != 0) @(negedge clk);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/cdd_pkg.sv
hdl/cdd_if.sv
hdl/cdd_isqrt.sv
hdl/cdd_div.sv
hdl/codel_drop_decider.sv
verif/codel_drop_decider_tb.sv
